/* rtl/core/lups_pkg.sv */
package lups_pkg;

  localparam int WORD_W = 32;
  localparam int SUMW   = 40;

  localparam logic signed [WORD_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] Q_MIN = 32'sh8000_0000;

  localparam logic [1:0] KIND_LOAD_A = 2'd0;
  localparam logic [1:0] KIND_LOAD_B = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;

  typedef struct packed {
    logic                     start;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [WORD_W-1:0] q;
  } div_rsp_t;

  function automatic logic [WORD_W-1:0] mag32(input logic signed [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v + 32'd1) : v;
  endfunction

  // magnitude with sign back to a saturated word
  function automatic logic signed [WORD_W-1:0] sat_mag(input logic neg,
                                                      input logic [63:0] m);
    if (neg) begin
      if (m >= 64'h8000_0000) return Q_MIN;
      return -$signed(m[WORD_W-1:0]);
    end
    if (m > 64'h7FFF_FFFF) return Q_MAX;
    return $signed(m[WORD_W-1:0]);
  endfunction

  function automatic logic signed [WORD_W-1:0] sat_sum(input logic signed [SUMW-1:0] v);
    if (v > SUMW'(Q_MAX)) return Q_MAX;
    if (v < SUMW'(Q_MIN)) return Q_MIN;
    return v[WORD_W-1:0];
  endfunction

endpackage

/* rtl/core/lups_if.sv */
interface lups_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          kind;
  logic [3:0]          row;
  logic [3:0]          col;
  logic signed [31:0]  value;

  modport source (output valid, kind, row, col, value, input ready);
  modport sink   (input valid, kind, row, col, value, output ready);
endinterface

interface lups_out_if;
  logic                valid;
  logic                ready;
  logic [3:0]          index;
  logic signed [31:0]  solution;
  logic signed [31:0]  determinant;
  logic                singular;
  logic                zero_pivot;
  logic                last;

  modport source (output valid, index, solution, determinant, singular, zero_pivot, last,
                  input ready);
  modport sink   (input valid, index, solution, determinant, singular, zero_pivot, last,
                  output ready);
endinterface

interface lups_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/lups_ram.sv */
module lups_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/lups_div.sv */
module lups_div import lups_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int NW   = WORD_W + FRAC_BITS;
  localparam int CNTW = $clog2(NW + 1);

  logic              busy;
  logic [CNTW-1:0]   cnt;
  logic [NW-1:0]     numr;
  logic [NW-1:0]     quo;
  logic [WORD_W:0]   rem;
  logic [WORD_W-1:0] den;
  logic              neg;

  logic [WORD_W:0]   rem_sh;
  logic              ge;
  logic [WORD_W:0]   rem_nx;
  logic [NW-1:0]     quo_nx;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem[WORD_W-1:0], numr[NW-1]};
    ge     = rem_sh >= {1'b0, den};
    rem_nx = ge ? (rem_sh - {1'b0, den}) : rem_sh;
    quo_nx = {quo[NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        neg <= req.a[WORD_W-1] != req.b[WORD_W-1];
        if (req.b == '0) begin
          rsp.done <= 1'b1;
          if (req.a == '0) rsp.q <= '0;
          else rsp.q <= req.a[WORD_W-1] ? Q_MIN : Q_MAX;
        end else begin
          busy <= 1'b1;
          cnt  <= CNTW'(NW);
          numr <= (NW'(mag32(req.a)) << FRAC_BITS) + NW'(mag32(req.b) >> 1);
          den  <= mag32(req.b);
          rem  <= '0;
          quo  <= '0;
        end
      end else if (busy) begin
        rem  <= rem_nx;
        numr <= numr << 1;
        quo  <= quo_nx;
        cnt  <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          rsp.q    <= sat_mag(neg, 64'(quo_nx));
        end
      end
    end
  end

endmodule

/* rtl/core/lu_pivot_linear_solver.sv */
// Load words: one per cycle while idle, no result. Start word: copies the matrix and
// right-hand side into the working memory, then factors, forms the determinant and solves.
// Elimination runs one divide per eliminated row and one multiply per updated element;
// the result words then follow, one word per row.
// Reset clears control, sets dimension 16 and threshold 1; stores are undefined.
module lu_pivot_linear_solver import lups_pkg::*; #(
  parameter int MAX_DIM   = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  lups_in_if.sink    item,
  lups_out_if.source result,
  lups_cfg_if.sink   cfg
);

  localparam int AW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int MAW    = 2 * AW;
  localparam int MDEPTH = 1 << MAW;
  localparam int RDEPTH = 1 << AW;
  localparam int NCAP   = (MAX_DIM < 16) ? MAX_DIM : 16;
  localparam int CW     = $clog2(NCAP + 1);
  localparam logic signed [WORD_W-1:0] ONE = 32'sd1 <<< FRAC_BITS;

  localparam logic [5:0] ST_IDLE = 6'd0,  ST_COPY = 6'd1,  ST_COPY_END = 6'd2,
    ST_PIV_INIT = 6'd3, ST_SCAN_RD = 6'd4, ST_SCAN_WT = 6'd5, ST_CMP1 = 6'd6,
    ST_CMP2 = 6'd7, ST_CMP3 = 6'd8, ST_CMP4 = 6'd9, ST_SWAP_CHK = 6'd10,
    ST_SW_RD1 = 6'd11, ST_SW_RD2 = 6'd12, ST_SW_WR1 = 6'd13, ST_SW_WR2 = 6'd14,
    ST_SWX_RD1 = 6'd15, ST_SWX_RD2 = 6'd16, ST_SWX_WR1 = 6'd17, ST_SWX_WR2 = 6'd18,
    ST_PIVRD = 6'd19, ST_PIVWT = 6'd20, ST_ELIM_ROW = 6'd21, ST_ELIM_DIV = 6'd22,
    ST_ELIM_DWT = 6'd23, ST_UPD_HEAD = 6'd24, ST_UPD_MUL = 6'd25, ST_UPD_WT = 6'd26,
    ST_UPD_WR = 6'd27, ST_DET_INIT = 6'd28, ST_DET_HEAD = 6'd29, ST_DET_MUL = 6'd30,
    ST_DET_WT = 6'd31, ST_DET_UPD = 6'd32, ST_SUB_HEAD = 6'd33, ST_SUB_TERM = 6'd34,
    ST_SUB_MUL = 6'd35, ST_SUB_WT = 6'd36, ST_SUB_ACC = 6'd37, ST_SUB_FIN = 6'd38,
    ST_SUB_DWT = 6'd39, ST_OUT_RD = 6'd40, ST_OUT_LD = 6'd41, ST_OUT_WT = 6'd42;

  function automatic logic [MAW-1:0] maddr(input logic [CW-1:0] r, input logic [CW-1:0] c);
    return {AW'(r), AW'(c)};
  endfunction

  function automatic logic signed [WORD_W-1:0] qround(input logic neg, input logic [63:0] p);
    logic [63:0] r;
    r = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return sat_mag(neg, r);
  endfunction

  logic [5:0]  state;
  logic [4:0]  dimension;
  logic [30:0] threshold;

  logic [CW-1:0] n, i, j, k, best;
  logic          bwd;
  logic [WORD_W-1:0] num, scale, bnum, bden;
  logic [63:0]   p1;
  logic signed [WORD_W-1:0] piv, mval, aval, det;
  logic signed [SUMW-1:0]   sacc;
  logic          zp, sign;

  logic [WORD_W-1:0] op_a, op_b;
  logic              op_neg;
  logic [63:0]       prod;

  logic [MAW-1:0] cp, cp_d;
  logic           cpv;

  logic           out_valid;
  logic [3:0]     out_index;
  logic signed [WORD_W-1:0] out_sol, out_det;
  logic           out_sing, out_zp, out_last;

  // memories
  logic            m_we, w_we, r_we, x_we;
  logic [MAW-1:0]  m_waddr, w_waddr, w_raddr;
  logic [AW-1:0]   r_waddr, x_waddr, x_raddr;
  logic [WORD_W-1:0] m_wdata, w_wdata, r_wdata, x_wdata;
  logic [WORD_W-1:0] m_rdata, w_rdata, r_rdata, x_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc, row_ok, col_ok, last_i;
  logic signed [WORD_W-1:0] qres, sub_t, upd_val;
  logic [CW-1:0] jend, dim_n;

  assign item.ready = state == ST_IDLE;
  assign in_acc     = item.valid && item.ready;
  assign row_ok     = 32'(item.row) < 32'(MAX_DIM);
  assign col_ok     = 32'(item.col) < 32'(MAX_DIM);
  assign cfg.ready  = 1'b1;

  assign result.valid       = out_valid;
  assign result.index       = out_index;
  assign result.solution    = out_sol;
  assign result.determinant = out_det;
  assign result.singular    = out_sing;
  assign result.zero_pivot  = out_zp;
  assign result.last        = out_last;

  always_comb begin
    if (dimension == '0) dim_n = CW'(1);
    else if (32'(dimension) > NCAP) dim_n = CW'(NCAP);
    else dim_n = CW'(dimension);
  end

  assign qres    = qround(op_neg, prod);
  assign sub_t   = sat_sum(SUMW'($signed(x_rdata)) - sacc);
  assign upd_val = sat_sum(SUMW'(aval) - SUMW'(qres));
  assign jend    = bwd ? n : i;
  assign last_i  = i == (n - CW'(1));

  always_comb begin
    m_we    = in_acc && item.kind == KIND_LOAD_A && row_ok && col_ok;
    m_waddr = {AW'(item.row), AW'(item.col)};
    m_wdata = item.value;
    r_we    = in_acc && item.kind == KIND_LOAD_B && row_ok;
    r_waddr = AW'(item.row);
    r_wdata = item.value;

    w_we    = 1'b0;
    w_waddr = maddr(i, k);
    w_wdata = w_rdata;
    w_raddr = maddr(i, k);
    x_we    = 1'b0;
    x_waddr = AW'(i);
    x_wdata = x_rdata;
    x_raddr = AW'(i);
    div_req = '0;

    if (cpv) begin
      w_we    = 1'b1;
      w_waddr = cp_d;
      w_wdata = m_rdata;
      x_we    = cp_d[MAW-1:AW] == '0;
      x_waddr = cp_d[AW-1:0];
      x_wdata = r_rdata;
    end

    unique case (state)
      ST_SCAN_RD:  w_raddr = maddr(j, k);
      ST_SW_RD2:   w_raddr = maddr(best, k);
      ST_SW_WR1:   w_we = 1'b1;
      ST_SW_WR2: begin
        w_we    = 1'b1;
        w_waddr = maddr(best, k);
        w_wdata = aval;
      end
      ST_SWX_RD2:  x_raddr = AW'(best);
      ST_SWX_WR1:  x_we = 1'b1;
      ST_SWX_WR2: begin
        x_we    = 1'b1;
        x_waddr = AW'(best);
        x_wdata = aval;
      end
      ST_PIVRD, ST_DET_HEAD: w_raddr = maddr(i, i);
      ST_ELIM_ROW: w_raddr = maddr(j, i);
      ST_ELIM_DIV: begin
        div_req.start = 1'b1;
        div_req.a     = w_rdata;
        div_req.b     = piv;
      end
      ST_ELIM_DWT: begin
        w_we    = div_rsp.done;
        w_waddr = maddr(j, i);
        w_wdata = div_rsp.q;
      end
      ST_UPD_MUL:  w_raddr = maddr(j, k);
      ST_UPD_WR: begin
        w_we    = 1'b1;
        w_waddr = maddr(j, k);
        w_wdata = upd_val;
      end
      ST_SUB_TERM: begin
        if (j == jend) begin
          w_raddr = maddr(i, i);
        end else begin
          w_raddr = maddr(i, j);
          x_raddr = AW'(j);
        end
      end
      ST_SUB_FIN: begin
        if (bwd) begin
          div_req.start = 1'b1;
          div_req.a     = sub_t;
          div_req.b     = w_rdata;
        end else begin
          x_we    = 1'b1;
          x_wdata = sub_t;
        end
      end
      ST_SUB_DWT: begin
        x_we    = div_rsp.done;
        x_wdata = div_rsp.q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      dimension <= 5'd16;
      threshold <= 31'd1;
      out_valid <= 1'b0;
      cpv       <= 1'b0;
    end else begin
      if (cfg.valid) begin
        if (cfg.index == REG_DIMENSION) dimension <= cfg.data[4:0];
        else if (cfg.index == REG_THRESHOLD) threshold <= cfg.data[30:0];
      end
      cpv <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_acc && item.kind == KIND_START) begin
            n     <= dim_n;
            zp    <= 1'b0;
            sign  <= 1'b0;
            cp    <= '0;
            state <= ST_COPY;
          end
        end
        ST_COPY: begin
          cpv  <= 1'b1;
          cp_d <= cp;
          cp   <= cp + MAW'(1);
          if (cp == MAW'(MDEPTH - 1)) state <= ST_COPY_END;
        end
        ST_COPY_END: begin
          i     <= '0;
          state <= ST_PIV_INIT;
        end
        ST_PIV_INIT: begin
          if (i == n) begin
            state <= ST_DET_INIT;
          end else begin
            best  <= i;
            bnum  <= '0;
            bden  <= 32'd1;
            j     <= i;
            k     <= i;
            scale <= '0;
            state <= ST_SCAN_RD;
          end
        end
        ST_SCAN_RD: state <= ST_SCAN_WT;
        ST_SCAN_WT: begin
          if (k == i) num <= mag32(w_rdata);
          if (mag32(w_rdata) > scale) scale <= mag32(w_rdata);
          if (k == n - CW'(1)) begin
            state <= ST_CMP1;
          end else begin
            k     <= k + CW'(1);
            state <= ST_SCAN_RD;
          end
        end
        ST_CMP1: begin
          op_a  <= num;
          op_b  <= bden;
          state <= ST_CMP2;
        end
        ST_CMP2: begin
          op_a  <= bnum;
          op_b  <= scale;
          state <= ST_CMP3;
        end
        ST_CMP3: begin
          p1    <= prod;
          state <= ST_CMP4;
        end
        ST_CMP4: begin
          // cross-multiplied ratio compare, strictly greater wins
          if (num != '0 && p1 > prod) begin
            bnum <= num;
            bden <= scale;
            best <= j;
          end
          if (j == n - CW'(1)) begin
            state <= ST_SWAP_CHK;
          end else begin
            j     <= j + CW'(1);
            k     <= i;
            scale <= '0;
            state <= ST_SCAN_RD;
          end
        end
        ST_SWAP_CHK: begin
          if (best != i) begin
            sign  <= ~sign;
            k     <= '0;
            state <= ST_SW_RD1;
          end else begin
            state <= ST_PIVRD;
          end
        end
        ST_SW_RD1: state <= ST_SW_RD2;
        ST_SW_RD2: begin
          aval  <= w_rdata;
          state <= ST_SW_WR1;
        end
        ST_SW_WR1: state <= ST_SW_WR2;
        ST_SW_WR2: begin
          if (k == n - CW'(1)) begin
            state <= ST_SWX_RD1;
          end else begin
            k     <= k + CW'(1);
            state <= ST_SW_RD1;
          end
        end
        ST_SWX_RD1: state <= ST_SWX_RD2;
        ST_SWX_RD2: begin
          aval  <= x_rdata;
          state <= ST_SWX_WR1;
        end
        ST_SWX_WR1: state <= ST_SWX_WR2;
        ST_SWX_WR2: state <= ST_PIVRD;
        ST_PIVRD:   state <= ST_PIVWT;
        ST_PIVWT: begin
          piv <= w_rdata;
          if (w_rdata == '0) zp <= 1'b1;
          j     <= i + CW'(1);
          state <= ST_ELIM_ROW;
        end
        ST_ELIM_ROW: begin
          if (j >= n) begin
            i     <= i + CW'(1);
            state <= ST_PIV_INIT;
          end else begin
            state <= ST_ELIM_DIV;
          end
        end
        ST_ELIM_DIV: state <= ST_ELIM_DWT;
        ST_ELIM_DWT: begin
          if (div_rsp.done) begin
            mval  <= div_rsp.q;
            k     <= i + CW'(1);
            state <= ST_UPD_HEAD;
          end
        end
        ST_UPD_HEAD: begin
          if (k >= n) begin
            j     <= j + CW'(1);
            state <= ST_ELIM_ROW;
          end else begin
            state <= ST_UPD_MUL;
          end
        end
        ST_UPD_MUL: begin
          op_a   <= mag32(mval);
          op_b   <= mag32(w_rdata);
          op_neg <= mval[WORD_W-1] != w_rdata[WORD_W-1];
          state  <= ST_UPD_WT;
        end
        ST_UPD_WT: begin
          aval  <= w_rdata;
          state <= ST_UPD_WR;
        end
        ST_UPD_WR: begin
          k     <= k + CW'(1);
          state <= ST_UPD_HEAD;
        end
        ST_DET_INIT: begin
          det   <= sign ? -ONE : ONE;
          i     <= '0;
          state <= ST_DET_HEAD;
        end
        ST_DET_HEAD: begin
          if (i == n) begin
            i     <= '0;
            bwd   <= 1'b0;
            state <= ST_SUB_HEAD;
          end else begin
            state <= ST_DET_MUL;
          end
        end
        ST_DET_MUL: begin
          op_a   <= mag32(det);
          op_b   <= mag32(w_rdata);
          op_neg <= det[WORD_W-1] != w_rdata[WORD_W-1];
          state  <= ST_DET_WT;
        end
        ST_DET_WT: state <= ST_DET_UPD;
        ST_DET_UPD: begin
          det   <= qres;
          i     <= i + CW'(1);
          state <= ST_DET_HEAD;
        end
        ST_SUB_HEAD: begin
          sacc  <= '0;
          j     <= bwd ? (i + CW'(1)) : '0;
          state <= ST_SUB_TERM;
        end
        ST_SUB_TERM: state <= (j == jend) ? ST_SUB_FIN : ST_SUB_MUL;
        ST_SUB_MUL: begin
          op_a   <= mag32(w_rdata);
          op_b   <= mag32(x_rdata);
          op_neg <= w_rdata[WORD_W-1] != x_rdata[WORD_W-1];
          state  <= ST_SUB_WT;
        end
        ST_SUB_WT: state <= ST_SUB_ACC;
        ST_SUB_ACC: begin
          sacc  <= sacc + SUMW'(qres);
          j     <= j + CW'(1);
          state <= ST_SUB_TERM;
        end
        ST_SUB_FIN: begin
          if (bwd) begin
            state <= ST_SUB_DWT;
          end else if (last_i) begin
            bwd   <= 1'b1;
            state <= ST_SUB_HEAD;
          end else begin
            i     <= i + CW'(1);
            state <= ST_SUB_HEAD;
          end
        end
        ST_SUB_DWT: begin
          if (div_rsp.done) begin
            if (i == '0) begin
              state <= ST_OUT_RD;
            end else begin
              i     <= i - CW'(1);
              state <= ST_SUB_HEAD;
            end
          end
        end
        ST_OUT_RD: state <= ST_OUT_LD;
        ST_OUT_LD: begin
          out_valid <= 1'b1;
          out_index <= 4'(i);
          out_sol   <= x_rdata;
          out_det   <= det;
          out_sing  <= mag32(det) <= 32'(threshold);
          out_zp    <= zp;
          out_last  <= last_i;
          state     <= ST_OUT_WT;
        end
        ST_OUT_WT: begin
          if (result.ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              state <= ST_IDLE;
            end else begin
              i     <= i + CW'(1);
              state <= ST_OUT_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  lups_ram #(.WIDTH(WORD_W), .DEPTH(MDEPTH)) u_mstore (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(cp), .rdata(m_rdata)
  );

  lups_ram #(.WIDTH(WORD_W), .DEPTH(RDEPTH)) u_rstore (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata), .raddr(cp[AW-1:0]),
    .rdata(r_rdata)
  );

  lups_ram #(.WIDTH(WORD_W), .DEPTH(MDEPTH)) u_work (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr),
    .rdata(w_rdata)
  );

  lups_ram #(.WIDTH(WORD_W), .DEPTH(RDEPTH)) u_xvec (
    .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(x_wdata), .raddr(x_raddr),
    .rdata(x_rdata)
  );

  lups_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp)
  );

endmodule
